// ===== rtl/frct_pkg.sv =====
// Shared types, constants and the luma function for the ring corner test.
// No dependencies; used by every module of the block.
`default_nettype none

package frct_pkg;

   localparam int PixelWidth = 24;
   localparam int LumaWidth = 10;
   localparam int ThreshWidth = 9;
   localparam int RingPoints = 16;
   localparam int RunNeeded = 9;
   localparam int ProductWidth = 18;

   typedef logic [PixelWidth-1:0] pixel_type;
   typedef logic [LumaWidth-1:0] luma_type;
   typedef logic signed [ThreshWidth-1:0] thresh_type;
   typedef logic [RingPoints-1:0] ring_bits_type;

   localparam logic [ProductWidth-1:0] CoefRed = 18'd305;
   localparam logic [ProductWidth-1:0] CoefGreen = 18'd599;
   localparam logic [ProductWidth-1:0] CoefBlue = 18'd120;
   localparam int LumaShift = 8;
   localparam pixel_type CornerColor = 24'hFF0000;
   localparam thresh_type ThreshReset = 9'sd20;

   function automatic luma_type luma_of(input pixel_type px);
      logic [ProductWidth-1:0] sum;
      sum = ProductWidth'(px[7:0]) * CoefRed
          + ProductWidth'(px[15:8]) * CoefGreen
          + ProductWidth'(px[23:16]) * CoefBlue;
      return sum[LumaShift +: LumaWidth];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/frct_luma.sv =====
// Luma stage of one pixel lane: weighted RGB sum, registered.
// Depends on frct_pkg.
`default_nettype none

module frct_luma (
   input  wire logic              clock,
   input  wire logic              load,
   input  wire frct_pkg::pixel_type pixel,
   output frct_pkg::luma_type     luma_ff
);

   frct_pkg::luma_type luma_in;

   assign luma_in = load ? frct_pkg::luma_of(pixel) : luma_ff;

   always_ff @(posedge clock) begin
      luma_ff <= luma_in;
   end

endmodule

`default_nettype wire

// ===== rtl/frct_lane.sv =====
// Compare stage of one lane: flags when two lumas differ by more than the threshold.
// Depends on frct_pkg.
`default_nettype none

module frct_lane (
   input  wire logic               clock,
   input  wire logic               load,
   input  wire frct_pkg::luma_type luma_a,
   input  wire frct_pkg::luma_type luma_b,
   input  wire frct_pkg::thresh_type threshold,
   output logic                    differ_ff
);

   logic signed [10:0] diff;
   logic [10:0] mag;
   logic differ_in;

   assign diff = $signed({1'b0, luma_a}) - $signed({1'b0, luma_b});
   assign mag = diff[10] ? 11'(-diff) : 11'(diff);
   assign differ_in = load ? ($signed({1'b0, mag}) > $signed(12'(threshold))) : differ_ff;

   always_ff @(posedge clock) begin
      differ_ff <= differ_in;
   end

endmodule

`default_nettype wire

// ===== rtl/frct_merge.sv =====
// Merge stage: combines the lane flags into the pretests and the run test, registered.
// Depends on frct_pkg.
`default_nettype none

module frct_merge (
   input  wire logic                   clock,
   input  wire logic                   load,
   input  wire frct_pkg::ring_bits_type differ,
   input  wire logic                   ends_differ,
   input  wire frct_pkg::pixel_type    center_pixel,
   output logic                        is_corner_ff,
   output frct_pkg::pixel_type         marked_pixel_ff
);

   logic [2:0] near_count;
   logic [7:0] run_found;
   logic corner;
   logic is_corner_in;
   frct_pkg::pixel_type marked_pixel_in;

   always_comb begin
      near_count = 3'(!differ[0]) + 3'(!differ[4]) + 3'(!differ[8]) + 3'(!differ[12]);
      for (int i = 0; i < 8; i++) begin
         run_found[i] = &differ[i +: frct_pkg::RunNeeded];
      end
      corner = ends_differ && (near_count <= 3'd1) && (|run_found);
   end

   assign is_corner_in = load ? corner : is_corner_ff;
   assign marked_pixel_in = load ? (corner ? frct_pkg::CornerColor : center_pixel)
                                 : marked_pixel_ff;

   always_ff @(posedge clock) begin
      is_corner_ff <= is_corner_in;
      marked_pixel_ff <= marked_pixel_in;
   end

endmodule

`default_nettype wire

// ===== rtl/fast_ring_corner_test_core.sv =====
// Ring corner test top level: 17 luma lanes, 17 compare lanes and a merge stage.
// Items pass the luma, compare and merge registers; one per cycle unless rsp_stall is high.
// The three stages advance independently, so a bubble ahead of a stalled result is filled.
// Reset clears the stage valid bits and sets the threshold to 20.
// Depends on frct_pkg, frct_luma, frct_lane and frct_merge.
`default_nettype none

module fast_ring_corner_test_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [23:0] req_center_pixel,
   input  wire logic [47:0] req_ring_pair_0,
   input  wire logic [47:0] req_ring_pair_1,
   input  wire logic [47:0] req_ring_pair_2,
   input  wire logic [47:0] req_ring_pair_3,
   input  wire logic [47:0] req_ring_pair_4,
   input  wire logic [47:0] req_ring_pair_5,
   input  wire logic [47:0] req_ring_pair_6,
   input  wire logic [47:0] req_ring_pair_7,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_is_corner,
   output logic [23:0]      rsp_marked_pixel,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic signed [8:0] csr_threshold
);

   frct_pkg::thresh_type threshold_ff, threshold_in;
   logic valid1_ff, valid1_in, valid2_ff, valid2_in, valid3_ff, valid3_in;
   logic ready1, ready2, ready3;
   frct_pkg::pixel_type center1_ff, center1_in, center2_ff, center2_in;
   frct_pkg::pixel_type ring_px [frct_pkg::RingPoints];
   frct_pkg::luma_type ring_luma [frct_pkg::RingPoints];
   frct_pkg::luma_type center_luma;
   frct_pkg::ring_bits_type differ;
   logic ends_differ;
   logic [383:0] ring_flat;

   assign csr_ready = 1'b1;
   assign ready3 = !valid3_ff || !rsp_stall;
   assign ready2 = !valid2_ff || ready3;
   assign ready1 = !valid1_ff || ready2;
   assign req_stall = !ready1;
   assign rsp_valid = valid3_ff;

   assign threshold_in = (csr_valid && csr_ready) ? csr_threshold : threshold_ff;
   assign valid1_in = ready1 ? req_valid : valid1_ff;
   assign valid2_in = ready2 ? valid1_ff : valid2_ff;
   assign valid3_in = ready3 ? valid2_ff : valid3_ff;
   assign center1_in = ready1 ? req_center_pixel : center1_ff;
   assign center2_in = ready2 ? center1_ff : center2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= frct_pkg::ThreshReset;
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         valid1_ff <= valid1_in;
         valid2_ff <= valid2_in;
         valid3_ff <= valid3_in;
      end
      center1_ff <= center1_in;
      center2_ff <= center2_in;
   end

   assign ring_flat = {req_ring_pair_7, req_ring_pair_6, req_ring_pair_5, req_ring_pair_4,
                       req_ring_pair_3, req_ring_pair_2, req_ring_pair_1, req_ring_pair_0};

   frct_luma u_center_luma (
      .clock   (clock),
      .load    (ready1),
      .pixel   (req_center_pixel),
      .luma_ff (center_luma)
   );

   for (genvar g = 0; g < frct_pkg::RingPoints; g++) begin : g_lane
      assign ring_px[g] = ring_flat[g*frct_pkg::PixelWidth +: frct_pkg::PixelWidth];

      frct_luma u_luma (
         .clock   (clock),
         .load    (ready1),
         .pixel   (ring_px[g]),
         .luma_ff (ring_luma[g])
      );

      frct_lane u_lane (
         .clock     (clock),
         .load      (ready2),
         .luma_a    (ring_luma[g]),
         .luma_b    (center_luma),
         .threshold (threshold_ff),
         .differ_ff (differ[g])
      );
   end

   frct_lane u_ends (
      .clock     (clock),
      .load      (ready2),
      .luma_a    (ring_luma[8]),
      .luma_b    (ring_luma[0]),
      .threshold (threshold_ff),
      .differ_ff (ends_differ)
   );

   frct_merge u_merge (
      .clock           (clock),
      .load            (ready3),
      .differ          (differ),
      .ends_differ     (ends_differ),
      .center_pixel    (center2_ff),
      .is_corner_ff    (rsp_is_corner),
      .marked_pixel_ff (rsp_marked_pixel)
   );

endmodule

`default_nettype wire

// ===== verif/tb_fast_ring_corner_test_core.sv =====
// Self-checking testbench for fast_ring_corner_test_core: directed windows, then random phases
// at several thresholds, with random idling on both channels. Depends on frct_pkg and the core.
`default_nettype none

module tb_fast_ring_corner_test_core;
   import frct_pkg::*;

   typedef struct packed {
      pixel_type             center;
      logic [15:0][23:0]     ring;
   } window_t;

   typedef struct packed {
      logic      is_corner;
      pixel_type marked_pixel;
   } corner_result_t;

   typedef enum logic {RowWindow, RowThreshold} row_kind_e;

   typedef struct {
      row_kind_e      kind;
      int             thr_value;
      window_t        win;
      bit             typed;
      corner_result_t want;
   } stim_row_t;

   localparam int IdleLimit = 2000;
   localparam int ItemsPerPhase = 75;
   localparam int RandomPhases = 8;
   localparam pixel_type White = 24'hFFFFFF;
   localparam pixel_type Black = 24'h000000;
   localparam pixel_type Gray = 24'h808080;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [23:0] req_center_pixel = '0;
   logic [47:0] req_ring_pair_0 = '0;
   logic [47:0] req_ring_pair_1 = '0;
   logic [47:0] req_ring_pair_2 = '0;
   logic [47:0] req_ring_pair_3 = '0;
   logic [47:0] req_ring_pair_4 = '0;
   logic [47:0] req_ring_pair_5 = '0;
   logic [47:0] req_ring_pair_6 = '0;
   logic [47:0] req_ring_pair_7 = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_is_corner;
   logic [23:0] rsp_marked_pixel;
   logic csr_valid = 1'b0;
   logic csr_ready;
   thresh_type csr_threshold = '0;

   corner_result_t expected_marks[$];
   stim_row_t directed_rows[$];
   int cur_threshold = 20;
   int mismatches = 0;
   int stall_left = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;

   fast_ring_corner_test_core u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_center_pixel(req_center_pixel),
      .req_ring_pair_0(req_ring_pair_0),
      .req_ring_pair_1(req_ring_pair_1),
      .req_ring_pair_2(req_ring_pair_2),
      .req_ring_pair_3(req_ring_pair_3),
      .req_ring_pair_4(req_ring_pair_4),
      .req_ring_pair_5(req_ring_pair_5),
      .req_ring_pair_6(req_ring_pair_6),
      .req_ring_pair_7(req_ring_pair_7),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_is_corner(rsp_is_corner),
      .rsp_marked_pixel(rsp_marked_pixel),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_threshold(csr_threshold)
   );

   always #6 clock = ~clock;

   function automatic int pixel_luma(pixel_type p);
      return (int'(p[7:0]) * int'(CoefRed) + int'(p[15:8]) * int'(CoefGreen)
            + int'(p[23:16]) * int'(CoefBlue)) >> LumaShift;
   endfunction

   function automatic bit lumas_close(int a, int b, int thr);
      int d;
      d = a - b;
      if (d < 0) begin
         d = -d;
      end
      return d <= thr;
   endfunction

   function automatic corner_result_t predict_corner(window_t w, int thr);
      int pc;
      int near;
      int run;
      int best;
      int lum[RingPoints];
      bit corner;
      corner_result_t res;
      pc = pixel_luma(w.center);
      for (int i = 0; i < RingPoints; i++) begin
         lum[i] = pixel_luma(w.ring[i]);
      end
      corner = 1'b0;
      if (!lumas_close(lum[8], lum[0], thr)) begin
         near = int'(lumas_close(pc, lum[8], thr)) + int'(lumas_close(pc, lum[0], thr))
              + int'(lumas_close(pc, lum[4], thr)) + int'(lumas_close(pc, lum[12], thr));
         if (near <= 1) begin
            run = 0;
            best = 0;
            for (int i = 0; i < RingPoints; i++) begin
               if (!lumas_close(lum[i], pc, thr)) begin
                  run++;
                  if (run > best) begin
                     best = run;
                  end
               end else begin
                  run = 0;
               end
            end
            corner = best >= RunNeeded;
         end
      end
      res.is_corner = corner;
      res.marked_pixel = corner ? CornerColor : w.center;
      return res;
   endfunction

   // Points first..last (wrapping when first > last) get the arc color, the rest the base.
   function automatic logic [15:0][23:0] ring_arc(pixel_type arc, pixel_type base,
                                                  int first, int last);
      logic [15:0][23:0] r;
      for (int i = 0; i < RingPoints; i++) begin
         if (first <= last) begin
            r[i] = (i >= first && i <= last) ? arc : base;
         end else begin
            r[i] = (i >= first || i <= last) ? arc : base;
         end
      end
      return r;
   endfunction

   function automatic int pick_idle_len();
      if ($urandom_range(0, 99) < 85) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic pixel_type pick_extreme(pixel_type center);
      case ($urandom_range(0, 3))
         0: return Black;
         1: return White;
         2: return center;
         default: return pixel_type'($urandom);
      endcase
   endfunction

   function automatic window_t random_window(int thr);
      window_t w;
      int cl;
      int start;
      int len;
      int kind;
      pixel_type p;
      kind = $urandom_range(0, 99);
      w.center = pixel_type'($urandom);
      if (kind < 60) begin
         cl = pixel_luma(w.center);
         start = $urandom_range(0, 15);
         len = $urandom_range(6, 16);
         for (int i = 0; i < RingPoints; i++) begin
            if (((i - start + RingPoints) % RingPoints) < len) begin
               p = pixel_type'($urandom);
               for (int t = 0; t < 8; t++) begin
                  if (!lumas_close(pixel_luma(p), cl, thr)) begin
                     break;
                  end
                  p = pixel_type'($urandom);
               end
            end else begin
               p = w.center ^ (pixel_type'($urandom) & 24'h030303);
            end
            if ($urandom_range(0, 19) == 0) begin
               p = pixel_type'($urandom);
            end
            w.ring[i] = p;
         end
      end else if (kind < 80) begin
         for (int i = 0; i < RingPoints; i++) begin
            w.ring[i] = pixel_type'($urandom);
         end
      end else begin
         w.center = pick_extreme(w.center);
         for (int i = 0; i < RingPoints; i++) begin
            w.ring[i] = pick_extreme(w.center);
         end
      end
      return w;
   endfunction

   task automatic send_window(window_t w, bit typed, corner_result_t want);
      int gap;
      gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : pick_idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_center_pixel <= w.center;
      req_ring_pair_0 <= w.ring[1:0];
      req_ring_pair_1 <= w.ring[3:2];
      req_ring_pair_2 <= w.ring[5:4];
      req_ring_pair_3 <= w.ring[7:6];
      req_ring_pair_4 <= w.ring[9:8];
      req_ring_pair_5 <= w.ring[11:10];
      req_ring_pair_6 <= w.ring[13:12];
      req_ring_pair_7 <= w.ring[15:14];
      do @(posedge clock); while (req_stall);
      expected_marks.push_back(typed ? want : predict_corner(w, cur_threshold));
   endtask

   task automatic set_threshold(int v);
      req_valid <= 1'b0;
      while (expected_marks.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_threshold <= thresh_type'(v);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_threshold = v;
   endtask

   task automatic add_window_row(window_t w, bit typed, logic corner, pixel_type pix);
      stim_row_t row;
      row.kind = RowWindow;
      row.thr_value = 0;
      row.win = w;
      row.typed = typed;
      row.want.is_corner = corner;
      row.want.marked_pixel = pix;
      directed_rows.push_back(row);
   endtask

   task automatic add_threshold_row(int v);
      stim_row_t row;
      row.kind = RowThreshold;
      row.thr_value = v;
      row.win = '0;
      row.typed = 1'b0;
      row.want = '0;
      directed_rows.push_back(row);
   endtask

   task automatic log_mismatch(string what, corner_result_t want, corner_result_t got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch (%s): expected corner=%0b pixel=%06h, got corner=%0b pixel=%06h",
                  what, want.is_corner, want.marked_pixel, got.is_corner, got.marked_pixel);
      end
   endtask

   always @(posedge clock) begin
      corner_result_t got;
      corner_result_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.is_corner = rsp_is_corner;
         got.marked_pixel = rsp_marked_pixel;
         if (expected_marks.size() == 0) begin
            log_mismatch("unexpected item", '0, got);
         end else begin
            want = expected_marks.pop_front();
            if (got.is_corner !== want.is_corner || got.marked_pixel !== want.marked_pixel) begin
               log_mismatch("field", want, got);
            end
         end
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = pick_idle_len() - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("tb_fast_ring_corner_test_core failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      window_t w;
      int thr;
      thresh_type raw;

      w.center = Black;
      w.ring = '0;
      add_window_row(w, 1'b1, 1'b0, Black);
      w.center = 24'h123456;
      w.ring = ring_arc(White, White, 0, 15);
      add_window_row(w, 1'b1, 1'b0, 24'h123456);
      w.center = Black;
      w.ring = ring_arc(White, White, 0, 15);
      w.ring[8] = Gray;
      add_window_row(w, 1'b1, 1'b1, CornerColor);
      w.ring = '0;
      w.ring[0] = 24'h050505;
      add_window_row(w, 1'b1, 1'b0, Black);
      w.ring[0] = 24'h060606;
      add_window_row(w, 1'b1, 1'b0, Black);
      w.ring = ring_arc(White, Black, 0, 8);
      w.ring[8] = Gray;
      add_window_row(w, 1'b1, 1'b1, CornerColor);
      w.ring = ring_arc(White, Black, 12, 7);
      add_window_row(w, 1'b1, 1'b0, Black);
      w.ring = ring_arc(White, Black, 4, 12);
      add_window_row(w, 1'b1, 1'b1, CornerColor);
      w.ring = ring_arc(White, Black, 11, 3);
      add_window_row(w, 1'b0, 1'b0, Black);
      w.center = White;
      w.ring = '1;
      add_window_row(w, 1'b1, 1'b0, White);
      w.center = 24'hA5C3E1;
      w.ring = {8{48'hAAAA_5555_F0F0}};
      add_window_row(w, 1'b0, 1'b0, Black);
      add_threshold_row(0);
      w.center = Gray;
      w.ring = ring_arc(Gray, Gray, 0, 15);
      add_window_row(w, 1'b1, 1'b0, Gray);
      w.center = Black;
      w.ring = '0;
      w.ring[0] = 24'h010101;
      add_window_row(w, 1'b1, 1'b0, Black);
      w.ring = ring_arc(24'h010101, Black, 0, 9);
      w.ring[8] = 24'h020202;
      add_window_row(w, 1'b0, 1'b0, Black);
      add_threshold_row(-1);
      w.center = Black;
      w.ring = '0;
      add_window_row(w, 1'b1, 1'b1, CornerColor);
      add_threshold_row(-256);
      w.center = 24'h00FF00;
      add_window_row(w, 1'b1, 1'b1, CornerColor);
      add_threshold_row(254);
      w.center = Black;
      w.ring = ring_arc(White, White, 0, 15);
      w.ring[8] = Gray;
      add_window_row(w, 1'b1, 1'b1, CornerColor);
      w.center = Gray;
      w.ring = ring_arc(White, White, 0, 15);
      w.ring[8] = Black;
      add_window_row(w, 1'b0, 1'b0, Black);
      w.ring[4] = 24'h8A8A8A;
      add_window_row(w, 1'b0, 1'b0, Black);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == RowThreshold) begin
            set_threshold(directed_rows[i].thr_value);
         end else begin
            send_window(directed_rows[i].win, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      for (int phase = 0; phase < RandomPhases; phase++) begin
         case (phase)
            0: thr = 20;
            1: thr = 0;
            2: thr = 254;
            3: thr = -256;
            4: thr = -1;
            7: begin
               raw = thresh_type'($urandom);
               thr = int'(raw);
            end
            default: thr = $urandom_range(0, 100);
         endcase
         set_threshold(thr);
         quiet = (phase == 5);
         for (int n = 0; n < ItemsPerPhase; n++) begin
            send_window(random_window(cur_threshold), 1'b0, '0);
         end
      end
      quiet = 1'b0;

      req_valid <= 1'b0;
      while (expected_marks.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_marks.size() == 0) begin
         $display("tb_fast_ring_corner_test_core passed");
      end else begin
         $display("tb_fast_ring_corner_test_core failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== fast_ring_corner_test_core.f =====
rtl/frct_pkg.sv
rtl/frct_luma.sv
rtl/frct_lane.sv
rtl/frct_merge.sv
rtl/fast_ring_corner_test_core.sv
verif/tb_fast_ring_corner_test_core.sv
